// ===== hdl/slps_pkg.sv =====
// Package for the status LED pattern sequencer.
// Holds the word types, status codes and register map; no dependencies.
package slps_pkg;

  localparam int unsigned NumRegs       = 7;
  localparam int unsigned RegWidth      = 16;
  localparam int unsigned AddrWidth     = 5;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned FlashPhases   = 6;
  localparam int unsigned StepMulWidth  = 19;
  localparam int unsigned TallyWidth    = 3;
  localparam int unsigned ConnBlinks    = 4;

  typedef enum logic [2:0] {
    ST_START        = 3'd0,
    ST_AP           = 3'd1,
    ST_CONNECTING   = 3'd2,
    ST_CONNECTED    = 3'd3,
    ST_RECONNECTING = 3'd4,
    ST_FAILED       = 3'd5,
    ST_NORMAL       = 3'd6,
    ST_INVALID      = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    REG_START_STEP   = 3'd0,
    REG_START_HOLD   = 3'd1,
    REG_AP_HALF      = 3'd2,
    REG_CONNECTING   = 3'd3,
    REG_CONNECTED    = 3'd4,
    REG_RECONNECTING = 3'd5,
    REG_FAILED       = 3'd6
  } reg_idx_e;

  typedef enum logic {
    FUNC_TICK   = 1'b0,
    FUNC_STATUS = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [2:0]  new_status;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic       led_level;
    logic [2:0] status_now;
  } out_word_t;

endpackage

// ===== hdl/status_led_pattern_sequencer_unit.sv =====
// Top level of the status LED pattern sequencer: input register, next-state logic,
// result register and the APB register file. Depends on slps_pkg.
//
// Usage: each input word is either a time tick (func 0) carrying the current
// millisecond count, or a status request (func 1). Every accepted word yields
// exactly one result word holding the LED level and the current status.
// Both channels use valid/ready. A word passes an input register and then a
// result register; its result word becomes valid when the word leaves the input
// register, which can wait while the result register is stalled.
// One word is accepted per cycle at full rate while the receiver takes each result;
// the single-pass update of the status, timer and blink registers sets that figure.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; further words wait until the result
// is taken.
// Reset clears both pipeline stages, sets start mode with dark LED and zero
// timers, and loads the default intervals into the APB registers.
// The APB registers should only be written while no word is in flight.
module status_led_pattern_sequencer_unit
  import slps_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  localparam int unsigned ExtWidth = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int unsigned CmpWidth = (TIME_WIDTH > StepMulWidth) ? TIME_WIDTH : StepMulWidth;

  typedef logic [TIME_WIDTH-1:0] time_t;

  logic [RegWidth-1:0] cfg_q [NumRegs];
  logic [2:0]          reg_idx;
  logic                cfg_wr;

  logic      in_vld_q;
  in_word_t  in_q;
  logic      out_vld_q;
  out_word_t out_q;
  logic      advance;

  logic [2:0]          mode_q, mode_d;
  time_t               last_q, last_d;
  time_t               start_q, start_d;
  logic                tog_q, tog_d;
  logic                pin_q, pin_d;
  logic [TallyWidth-1:0] tally_q, tally_d;

  logic [ExtWidth-1:0] now_ext;
  time_t               now_t;
  time_t               st_eff;
  time_t               lt_eff;
  time_t               el_start;
  time_t               el_last;
  time_t               el_conn;
  logic [RegWidth-1:0] interval;
  logic [StepMulWidth-1:0] mul [FlashPhases+1];
  logic [CmpWidth-1:0]     el_start_c;
  logic [FlashPhases:1]    ge;
  logic                    periodic_hit;
  logic [TallyWidth-1:0]   tally_eff;

  assign reg_idx = paddr[AddrWidth-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    if (32'(reg_idx) < NumRegs) begin
      prdata = DataWidth'(cfg_q[reg_idx]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_START_STEP]   <= 16'd200;
      cfg_q[REG_START_HOLD]   <= 16'd2000;
      cfg_q[REG_AP_HALF]      <= 16'd1000;
      cfg_q[REG_CONNECTING]   <= 16'd500;
      cfg_q[REG_CONNECTED]    <= 16'd150;
      cfg_q[REG_RECONNECTING] <= 16'd200;
      cfg_q[REG_FAILED]       <= 16'd100;
    end else if (cfg_wr && (32'(reg_idx) < NumRegs)) begin
      cfg_q[reg_idx] <= pwdata[RegWidth-1:0];
    end
  end

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  assign now_ext  = ExtWidth'(in_q.now_ms);
  assign now_t    = now_ext[TIME_WIDTH-1:0];
  assign st_eff   = (start_q == '0) ? now_t : start_q;
  assign lt_eff   = (last_q == '0) ? now_t : last_q;
  assign tally_eff = (last_q == '0) ? '0 : tally_q;
  assign el_start = now_t - st_eff;
  assign el_last  = now_t - last_q;
  assign el_conn  = now_t - lt_eff;
  assign el_start_c = CmpWidth'(el_start);

  assign mul[0] = '0;
  assign mul[1] = StepMulWidth'(cfg_q[REG_START_STEP]);
  assign mul[2] = mul[1] << 1;
  assign mul[3] = mul[2] + mul[1];
  assign mul[4] = mul[1] << 2;
  assign mul[5] = mul[4] + mul[1];
  assign mul[6] = mul[3] << 1;

  always_comb begin
    for (int k = 1; k <= FlashPhases; k++) begin
      ge[k] = el_start_c >= CmpWidth'(mul[k]);
    end
  end

  always_comb begin
    case (mode_q)
      ST_AP:           interval = cfg_q[REG_AP_HALF];
      ST_CONNECTING:   interval = cfg_q[REG_CONNECTING];
      ST_RECONNECTING: interval = cfg_q[REG_RECONNECTING];
      ST_FAILED:       interval = cfg_q[REG_FAILED];
      default:         interval = cfg_q[REG_CONNECTED];
    endcase
  end

  assign periodic_hit = CmpWidth'(el_last) >= CmpWidth'(interval);

  always_comb begin
    mode_d  = mode_q;
    last_d  = last_q;
    start_d = start_q;
    tog_d   = tog_q;
    pin_d   = pin_q;
    tally_d = tally_q;
    if (in_q.func == FUNC_TICK) begin
      case (mode_q)
        ST_START: begin
          start_d = st_eff;
          if (!ge[FlashPhases]) begin
            pin_d = !(^ge[FlashPhases-1:1]);
          end else begin
            pin_d = 1'b0;
            if (el_start_c > CmpWidth'(cfg_q[REG_START_HOLD])) begin
              mode_d = ST_AP;
            end
          end
        end
        ST_AP, ST_CONNECTING, ST_RECONNECTING, ST_FAILED: begin
          if (periodic_hit) begin
            tog_d  = !tog_q;
            pin_d  = !tog_q;
            last_d = now_t;
          end
        end
        ST_CONNECTED: begin
          last_d  = lt_eff;
          tally_d = tally_eff;
          if (32'(tally_eff) < ConnBlinks) begin
            if (CmpWidth'(el_conn) >= CmpWidth'(cfg_q[REG_CONNECTED])) begin
              tog_d   = !tog_q;
              pin_d   = !tog_q;
              last_d  = now_t;
              tally_d = tally_eff + TallyWidth'(1);
            end
          end else begin
            pin_d = 1'b0;
          end
        end
        ST_NORMAL: pin_d = 1'b1;
        default: ;
      endcase
    end else if ((in_q.new_status != ST_INVALID) && (in_q.new_status != mode_q)) begin
      mode_d  = in_q.new_status;
      last_d  = '0;
      start_d = '0;
      tally_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ST_START;
      last_q  <= '0;
      start_q <= '0;
      tog_q   <= 1'b0;
      pin_q   <= 1'b0;
      tally_q <= '0;
    end else if (advance) begin
      mode_q  <= mode_d;
      last_q  <= last_d;
      start_q <= start_d;
      tog_q   <= tog_d;
      pin_q   <= pin_d;
      tally_q <= tally_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.led_level  <= pin_d;
      out_q.status_now <= mode_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_mode_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != ST_INVALID)
    else $error("status register holds the unused code");

  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tally_q) <= ConnBlinks)
    else $error("connected blink tally overran");

  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.func == FUNC_STATUS && in_q.new_status != ST_INVALID &&
     in_q.new_status != mode_q)
    |=> (start_q == '0 && last_q == '0 && tally_q == '0))
    else $error("status change did not clear the timers");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_q)))
    else $error("stalled input word was lost or changed");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result word appeared without an input word");
`endif

endmodule
